// ===== design/p2c_pkg.sv =====
`default_nettype none

package p2c_pkg;

  // width of the range field and how many of its bits are used
  localparam int RangeW    = 16;
  localparam int RangeBits = 16;
  localparam logic [RangeW-1:0] RangeMask =
    (RangeBits >= RangeW) ? {RangeW{1'b1}} : RangeW'((32'd1 << RangeBits) - 32'd1);

  // number of micro-rotations, held to the table span 8..24
  localparam int CordicStepsSet = 16;
  localparam int CordicSteps =
    (CordicStepsSet < 8) ? 8 : ((CordicStepsSet > 24) ? 24 : CordicStepsSet);

  // pipeline depth: gain multiply, rotations, rounding
  localparam int NumStages = CordicSteps + 2;

  // datapath widths
  localparam int GainW = 30;
  localparam int ProdW = RangeW + GainW - 14;
  localparam int DataW = ProdW + 3;
  localparam int AngW  = 34;
  localparam int PosW  = 17;

  // half a turn in the angle accumulator, one full turn = 2^32
  localparam logic signed [AngW-1:0] HalfTurn = 34'sd2147483648;

  // bearing codes at which the angle leaves [-pi/2, pi/2]
  localparam logic signed [15:0] QuarterPos = 16'sd16384;
  localparam logic signed [15:0] QuarterNeg = -16'sd16384;

  // arctangent of 2^-i in turns scaled by 2^32
  localparam logic [29:0] AtanTurn [24] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
    30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
    30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
    30'd652,       30'd326,       30'd163,       30'd81
  };

  // rotation gain compensation in Q0.30 for 8..24 steps
  localparam logic [GainW-1:0] GainTable [17] = '{
    30'd652039507, 30'd652034532, 30'd652033289, 30'd652032978, 30'd652032900,
    30'd652032881, 30'd652032876, 30'd652032874, 30'd652032874, 30'd652032874,
    30'd652032874, 30'd652032874, 30'd652032874, 30'd652032874, 30'd652032874,
    30'd652032874, 30'd652032874
  };
  localparam logic [GainW-1:0] Gain = GainTable[CordicSteps-8];

  // fields that ride along with each request
  typedef struct packed {
    logic [RangeW-1:0] range;
    logic [15:0]       signature;
    logic              last;
  } side_t;

endpackage

`default_nettype wire

// ===== design/p2c_if.sv =====
`default_nettype none

// measurement channel
interface p2c_meas_if;
  logic              valid;
  logic              ready;
  logic [15:0]       range;
  logic signed [15:0] bearing;
  logic [15:0]       signature;
  logic              last;

  modport source (output valid, range, bearing, signature, last, input ready);
  modport sink (input valid, range, bearing, signature, last, output ready);
endinterface

// position channel
interface p2c_pos_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] pos_x;
  logic signed [16:0] pos_y;
  logic [15:0]        sig_out;
  logic               last_out;

  modport source (output valid, pos_x, pos_y, sig_out, last_out, input ready);
  modport sink (input valid, pos_x, pos_y, sig_out, last_out, output ready);
endinterface

`default_nettype wire

// ===== design/polar_to_cartesian.sv =====
// channel   dir  handshake      payload
// meas_i    in   valid/ready    range, bearing, signature, last
// pos_o     out  valid/ready    pos_x, pos_y, sig_out, last_out
//
// one request per cycle while a stage is free or pos_o is taken; the stages are:
// one gain-multiply stage, one stage per micro-rotation, one rounding stage.
// reset clears only the stage valid bits; payload registers are not reset.
// a stage holds while it and every later stage are full and pos_o is not taken;
// any empty stage downstream lets the pipe move up and meas_i stay ready.
`default_nettype none

module polar_to_cartesian (
  input  wire         clk_i,
  input  wire         rst_ni,
  p2c_meas_if.sink    meas_i,
  p2c_pos_if.source   pos_o
);

  localparam int Last = p2c_pkg::NumStages - 1;
  localparam int DW   = p2c_pkg::DataW;
  localparam int AW   = p2c_pkg::AngW;

  // stage valid bits and load enables
  logic [Last:0] v_q;
  logic [Last:0] en;

  // side fields per stage
  p2c_pkg::side_t side_q [p2c_pkg::NumStages];

  // gain stage
  logic [p2c_pkg::ProdW-1:0]    prod_q;
  logic                         neg_q;
  logic signed [AW-1:0]         z0_q;

  // rotation stages
  logic signed [DW-1:0] x_q [p2c_pkg::CordicSteps];
  logic signed [DW-1:0] y_q [p2c_pkg::CordicSteps];
  logic signed [AW-1:0] z_q [p2c_pkg::CordicSteps-1];

  // output stage
  logic signed [p2c_pkg::PosW-1:0] pos_x_q;
  logic signed [p2c_pkg::PosW-1:0] pos_y_q;

  logic in_acc;
  logic out_acc;

  assign in_acc  = meas_i.valid && meas_i.ready;
  assign out_acc = pos_o.valid && pos_o.ready;

  // a stage loads when it is empty or everything after it moves
  for (genvar k = 0; k <= Last; k++) begin : g_en
    assign en[k] = pos_o.ready | ~(&v_q[Last:k]);
  end

  assign meas_i.ready = en[0];

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= meas_i.valid;
      end
      for (int k = 1; k <= Last; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // side fields move along with each stage
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side_q[0].range     <= meas_i.range & p2c_pkg::RangeMask;
      side_q[0].signature <= meas_i.signature;
      side_q[0].last      <= meas_i.last;
    end
    for (int k = 1; k <= Last; k++) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // gain multiply and half-turn fold of the bearing
  logic [p2c_pkg::RangeW+p2c_pkg::GainW-1:0] mult;
  logic signed [AW-1:0]                      z_ext;
  logic                                      fold_hi;
  logic                                      fold_lo;

  always_comb begin
    mult    = {{p2c_pkg::GainW{1'b0}}, (meas_i.range & p2c_pkg::RangeMask)}
            * {{p2c_pkg::RangeW{1'b0}}, p2c_pkg::Gain};
    z_ext   = {{(AW-32){meas_i.bearing[15]}}, meas_i.bearing, 16'b0};
    fold_hi = meas_i.bearing > p2c_pkg::QuarterPos;
    fold_lo = meas_i.bearing < p2c_pkg::QuarterNeg;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      prod_q <= mult[p2c_pkg::RangeW+p2c_pkg::GainW-1:14];
      neg_q  <= fold_hi | fold_lo;
      if (fold_hi) begin
        z0_q <= z_ext - p2c_pkg::HalfTurn;
      end else if (fold_lo) begin
        z0_q <= z_ext + p2c_pkg::HalfTurn;
      end else begin
        z0_q <= z_ext;
      end
    end
  end

  // one micro-rotation per stage
  for (genvar k = 0; k < p2c_pkg::CordicSteps; k++) begin : g_rot
    logic signed [DW-1:0] xi;
    logic signed [DW-1:0] yi;
    logic signed [DW-1:0] xs;
    logic signed [DW-1:0] ys;
    logic signed [AW-1:0] zi;

    if (k == 0) begin : g_first
      logic signed [DW-1:0] x0;
      assign x0 = $signed({{(DW-p2c_pkg::ProdW){1'b0}}, prod_q});
      assign xi = neg_q ? -x0 : x0;
      assign yi = '0;
      assign zi = z0_q;
    end else begin : g_next
      assign xi = x_q[k-1];
      assign yi = y_q[k-1];
      assign zi = z_q[k-1];
    end

    assign xs = yi >>> k;
    assign ys = xi >>> k;

    always_ff @(posedge clk_i) begin
      if (en[k+1]) begin
        if (!zi[AW-1]) begin
          x_q[k] <= xi - xs;
          y_q[k] <= yi + ys;
        end else begin
          x_q[k] <= xi + xs;
          y_q[k] <= yi - ys;
        end
      end
    end

    // the angle is not needed after the final rotation
    if (k < p2c_pkg::CordicSteps - 1) begin : g_ang
      logic signed [AW-1:0] at;
      assign at = $signed({{(AW-30){1'b0}}, p2c_pkg::AtanTurn[k]});
      always_ff @(posedge clk_i) begin
        if (en[k+1]) begin
          z_q[k] <= zi[AW-1] ? zi + at : zi - at;
        end
      end
    end
  end

  // round to nearest, ties away from zero, magnitude held to the range
  function automatic logic signed [p2c_pkg::PosW-1:0] round_clamp(
    input logic signed [DW-1:0] v,
    input logic [p2c_pkg::RangeW-1:0] r
  );
    logic [DW-1:0]    mag;
    logic [DW-1:0]    sum;
    logic [DW-17:0]   q;
    logic [15:0]      qc;
    mag = v[DW-1] ? DW'(-v) : DW'(v);
    sum = mag + DW'(32768);
    q   = sum[DW-1:16];
    qc  = (q > (DW-16)'(r)) ? r : q[15:0];
    return v[DW-1] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
  endfunction

  always_ff @(posedge clk_i) begin
    if (en[Last]) begin
      pos_x_q <= round_clamp(x_q[p2c_pkg::CordicSteps-1], side_q[Last-1].range);
      pos_y_q <= round_clamp(y_q[p2c_pkg::CordicSteps-1], side_q[Last-1].range);
    end
  end

  // output drive
  assign pos_o.valid    = v_q[Last];
  assign pos_o.pos_x    = pos_x_q;
  assign pos_o.pos_y    = pos_y_q;
  assign pos_o.sig_out  = side_q[Last].signature;
  assign pos_o.last_out = side_q[Last].last;

  // pipeline occupancy follows accepted and delivered requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(v_q) == $past($countones(v_q)) + int'($past(in_acc)) - int'($past(out_acc)))
    else $error("stage valid count out of step with handshakes");

  // any empty stage keeps the input open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(&v_q) |-> meas_i.ready)
    else $error("input stalled with a free stage");

  // no coordinate magnitude exceeds the range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_o.valid |->
      (pos_x_q[16] ? -pos_x_q : pos_x_q) <= $signed({1'b0, side_q[Last].range}) &&
      (pos_y_q[16] ? -pos_y_q : pos_y_q) <= $signed({1'b0, side_q[Last].range}))
    else $error("coordinate exceeds range");

  // zero range gives the origin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_o.valid && side_q[Last].range == '0 |-> pos_x_q == '0 && pos_y_q == '0)
    else $error("zero range not mapped to origin");

endmodule

`default_nettype wire

// ===== tb/polar_to_cartesian_tb.sv =====
`default_nettype none

module polar_to_cartesian_tb;

  localparam int Steps      = p2c_pkg::CordicSteps;
  localparam int SettleCyc  = p2c_pkg::NumStages + 8;
  localparam int CycleLimit = 400000;
  localparam int RandItems  = 550;

  // arctangent of 2^-i, one full turn = 2^32
  localparam longint AtanTbl [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
  };

  // rotation gain compensation in Q0.30, indexed by steps - 8
  localparam longint GainQ30 [17] = '{
    652039507, 652034532, 652033289, 652032978, 652032900,
    652032881, 652032876, 652032874, 652032874, 652032874,
    652032874, 652032874, 652032874, 652032874, 652032874,
    652032874, 652032874
  };

  typedef struct packed {
    logic [15:0]        range;
    logic signed [15:0] bearing;
    logic [15:0]        signature;
    logic               last;
  } meas_req_t;

  typedef struct packed {
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic [15:0]        sig_out;
    logic               last_out;
  } pos_res_t;

  // expected positions in request order, plus the cordic predictor
  class position_book;
    pos_res_t pending_pos [$];
    int       mismatches;

    function new();
      mismatches = 0;
    endfunction

    // q16.16 rounding to an integer with ties away from zero, magnitude capped at the range
    static function longint round_q16(longint v, longint cap);
      longint mag;
      longint q;
      mag = (v < 0) ? -v : v;
      q = (mag + 32768) >>> 16;
      if (q > cap) q = cap;
      return (v < 0) ? -q : q;
    endfunction

    static function pos_res_t rotate_polar(meas_req_t m);
      longint   r;
      longint   x;
      longint   y;
      longint   z;
      longint   dx;
      longint   dy;
      pos_res_t res;
      r = longint'(m.range & p2c_pkg::RangeMask);
      x = (r * GainQ30[Steps-8]) >>> 14;
      y = 0;
      z = longint'(m.bearing) * 65536;
      // fold the back half-plane by a half turn
      if (z > (longint'(1) << 30)) begin
        x = -x;
        z = z - (longint'(1) << 31);
      end else if (z < -(longint'(1) << 30)) begin
        x = -x;
        z = z + (longint'(1) << 31);
      end
      // micro-rotations with flooring shifts
      for (int i = 0; i < Steps; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - AtanTbl[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + AtanTbl[i];
        end
      end
      res.pos_x    = 17'(round_q16(x, r));
      res.pos_y    = 17'(round_q16(y, r));
      res.sig_out  = m.signature;
      res.last_out = m.last;
      return res;
    endfunction

    function void note_request(meas_req_t m);
      pending_pos.push_back(rotate_polar(m));
    endfunction

    function void check_position(pos_res_t got);
      pos_res_t want;
      if (pending_pos.size() == 0) begin
        $error("position with no request pending: x %0d y %0d sig %h",
               got.pos_x, got.pos_y, got.sig_out);
        mismatches++;
        return;
      end
      want = pending_pos.pop_front();
      if (got.pos_x !== want.pos_x) begin
        $error("pos_x: expected %0d, got %0d", want.pos_x, got.pos_x);
        mismatches++;
      end
      if (got.pos_y !== want.pos_y) begin
        $error("pos_y: expected %0d, got %0d", want.pos_y, got.pos_y);
        mismatches++;
      end
      if (got.sig_out !== want.sig_out) begin
        $error("sig_out: expected %h, got %h", want.sig_out, got.sig_out);
        mismatches++;
      end
      if (got.last_out !== want.last_out) begin
        $error("last_out: expected %b, got %b", want.last_out, got.last_out);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   cycle_cnt;

  position_book book;

  p2c_meas_if meas_i ();
  p2c_pos_if  pos_o ();

  polar_to_cartesian dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .meas_i (meas_i),
    .pos_o  (pos_o)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // position sink: check what is taken, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni && pos_o.valid && pos_o.ready) begin
      book.check_position('{pos_x: pos_o.pos_x, pos_y: pos_o.pos_y,
                            sig_out: pos_o.sig_out, last_out: pos_o.last_out});
    end
    pos_o.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // one measurement request, held until taken
  task automatic send_meas(input meas_req_t m);
    while ($urandom_range(99) < tx_idle_pct) begin
      meas_i.valid <= 1'b0;
      @(posedge clk_i);
    end
    meas_i.valid     <= 1'b1;
    meas_i.range     <= m.range;
    meas_i.bearing   <= m.bearing;
    meas_i.signature <= m.signature;
    meas_i.last      <= m.last;
    @(posedge clk_i);
    while (!meas_i.ready) @(posedge clk_i);
    book.note_request(m);
  endtask

  // random requests, biased toward small, extreme and near-full ranges and toward quadrant edges, ends and zero bearing
  task automatic run_random(input int count);
    meas_req_t m;
    int        pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(7);
      case (pick)
        0: m.range = 16'($urandom_range(255));
        1: m.range = $urandom_range(1) ? 16'hffff : 16'h0000;
        2: m.range = 16'($urandom_range(65535, 61440));
        default: m.range = 16'($urandom);
      endcase
      pick = $urandom_range(7);
      case (pick)
        0: m.bearing = 16'(16384 + $urandom_range(8) - 4);
        1: m.bearing = 16'(-16384 + $urandom_range(8) - 4);
        2: m.bearing = $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
        3: m.bearing = 16'($urandom_range(8) - 4);
        default: m.bearing = 16'($urandom);
      endcase
      m.signature = 16'($urandom);
      m.last      = ($urandom_range(7) == 0);
      send_meas(m);
    end
  endtask

  initial begin
    int        dir_range [20];
    int        dir_bear [20];
    meas_req_t m;

    book        = new();
    cycle_cnt   = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rst_ni      = 1'b0;
    meas_i.valid     = 1'b0;
    meas_i.range     = '0;
    meas_i.bearing   = '0;
    meas_i.signature = '0;
    meas_i.last      = 1'b0;
    pos_o.ready      = 1'b0;

    // field extremes, quadrant edges and the minus-pi code
    dir_range = '{0, 65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535,
                  65535, 256, 256, 1, 128, 0, 65535, 32768, 65535, 1};
    dir_bear  = '{0, 0, 16384, -16384, -32768, 32767, -32767, 16385, -16385, 8192,
                  -8192, 24576, -24576, 16384, -32768, -32768, 16383, -16383, 1, -1};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 20; i++) begin
      m.range     = 16'(dir_range[i]);
      m.bearing   = 16'(dir_bear[i]);
      m.signature = (i % 3 == 0) ? 16'hffff : ((i % 3 == 1) ? 16'h0000 : 16'($urandom));
      m.last      = i[0];
      send_meas(m);
    end

    // idle mixes: slow sink, then slow source, then full rate
    tx_idle_pct = 36;
    rx_idle_pct = 86;
    run_random(RandItems / 3);
    tx_idle_pct = 86;
    rx_idle_pct = 36;
    run_random(RandItems / 3);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(RandItems - 2 * (RandItems / 3));
    meas_i.valid <= 1'b0;

    // drain
    while (book.pending_pos.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);

    if (book.mismatches == 0 && book.pending_pos.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
design/p2c_pkg.sv
design/p2c_if.sv
design/polar_to_cartesian.sv
tb/polar_to_cartesian_tb.sv
